[hdl/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants of the bounded priority queue: field widths,
// parameter defaults, request codes, controller states and command group.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // Field widths fixed by the request and result formats
    localparam int PRIO_W = 32;
    localparam int CFG_W  = 5;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_TAG_BITS = 16;

    // max_size after reset
    localparam logic [CFG_W-1:0] MAX_SIZE_RESET = 5'd16;

    // Request operation codes
    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted request
        logic exec;     // apply the operation to the sorted list
        logic load;     // fill the output register
    } dp_cmd_t;

endpackage

[hdl/bpq_req_if.sv]
// ----------------------------------------------------------------------------
// bpq_req_if
// Request channel of the bounded priority queue: valid/ready plus the
// operation, priority and tag of one request.
// ----------------------------------------------------------------------------
interface bpq_req_if
    import bpq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
);
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [PRIO_W-1:0]   priority_req;
    logic [TAG_BITS-1:0] tag;

    modport source (output valid, output cmd, output priority_req, output tag,
                    input ready);
    modport sink   (input valid, input cmd, input priority_req, input tag,
                    output ready);
endinterface

[hdl/bpq_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpq_rsp_if
// Result channel of the bounded priority queue: valid/ready plus the
// dequeued entry, drop flag, fill count and best/worst priority.
// ----------------------------------------------------------------------------
interface bpq_rsp_if
    import bpq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int CNT_W    = $clog2(DEF_CAPACITY + 1)
);
    logic                valid;
    logic                ready;
    logic                out_valid;
    logic [TAG_BITS-1:0] out_tag;
    logic [PRIO_W-1:0]   out_priority;
    logic                dropped;
    logic [CNT_W-1:0]    count;
    logic [PRIO_W-1:0]   best_priority;
    logic [PRIO_W-1:0]   worst_priority;

    modport source (output valid, output out_valid, output out_tag,
                    output out_priority, output dropped, output count,
                    output best_priority, output worst_priority,
                    input ready);
    modport sink   (input valid, input out_valid, input out_tag,
                    input out_priority, input dropped, input count,
                    input best_priority, input worst_priority,
                    output ready);
endinterface

[hdl/bpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bpq_ctrl
// Sequencing controller: accepts one request, runs the list update, then
// loads the output register once it is free, and tracks its occupancy.
// ----------------------------------------------------------------------------
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output dp_cmd_t dp_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        full_reg, full_next;
    logic        out_free;

    // Hold state and output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

    assign out_free  = !full_reg || rsp_ready;
    assign rsp_valid = full_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        dp_cmd     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                dp_cmd.capture = req_valid;
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                // wait for the output register to drain
                if (out_free)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fill on load, empty when the receiver takes the result
    always_comb
    begin
        if (dp_cmd.load)
            full_next = 1'b1;
        else if (rsp_ready)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

endmodule

[hdl/bpq_dp.sv]
// ----------------------------------------------------------------------------
// bpq_dp
// Datapath: request register, sorted row of (priority, tag) cells with a
// comparator per cell, result staging and the output register.
// ----------------------------------------------------------------------------
module bpq_dp
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int CNT_W    = $clog2(DEF_CAPACITY + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             dp_cmd,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                req_cmd,
    input  logic [PRIO_W-1:0]   req_priority,
    input  logic [TAG_BITS-1:0] req_tag,
    output logic                out_valid,
    output logic [TAG_BITS-1:0] out_tag,
    output logic [PRIO_W-1:0]   out_priority,
    output logic                dropped,
    output logic [CNT_W-1:0]    count,
    output logic [PRIO_W-1:0]   best_priority,
    output logic [PRIO_W-1:0]   worst_priority
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Configuration and request registers
    logic [CFG_W-1:0]    max_size_reg;
    cmd_t                cmd_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TAG_BITS-1:0] tag_reg;

    // Sorted list
    logic [PRIO_W-1:0]   entry_prio_reg [CAPACITY];
    logic [TAG_BITS-1:0] entry_tag_reg  [CAPACITY];
    logic [PRIO_W-1:0]   entry_prio_next [CAPACITY];
    logic [TAG_BITS-1:0] entry_tag_next  [CAPACITY];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] le;

    // Staged result of the last operation
    logic                hit_reg, hit_next;
    logic [TAG_BITS-1:0] rtag_reg, rtag_next;
    logic [PRIO_W-1:0]   rprio_reg, rprio_next;
    logic                drop_reg, drop_next;

    // Output register
    logic                out_valid_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic                dropped_reg;
    logic [CNT_W-1:0]    count_out_reg;
    logic [PRIO_W-1:0]   best_reg;
    logic [PRIO_W-1:0]   worst_reg;

    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CMP_W-1:0]    lim;
    logic                not_full;
    logic [IDX_W-1:0]    last_idx;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_size_reg <= MAX_SIZE_RESET;
        else if (cfg_we)
            max_size_reg <= cfg_wdata;
    end

    // Latch the accepted request
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd_t'(req_cmd);
            prio_reg <= req_priority;
            tag_reg  <= req_tag;
        end
    end

    // Per-cell compare and shift; le marks held entries not above the key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [PRIO_W-1:0]   dn_p, up_p;
        logic [TAG_BITS-1:0] dn_t, up_t;
        logic                ins;

        assign le[i] = (CNT_W'(i) < count_reg) && (entry_prio_reg[i] <= prio_reg);

        if (i == 0)
        begin : g_head
            assign dn_p = prio_reg;
            assign dn_t = tag_reg;
            assign ins  = 1'b1;
        end
        else
        begin : g_body
            assign dn_p = entry_prio_reg[i-1];
            assign dn_t = entry_tag_reg[i-1];
            assign ins  = le[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign up_p = entry_prio_reg[i];
            assign up_t = entry_tag_reg[i];
        end
        else
        begin : g_inner
            assign up_p = entry_prio_reg[i+1];
            assign up_t = entry_tag_reg[i+1];
        end

        // keep, take the new pair, or shift toward the tail / head
        always_comb
        begin
            if (cmd_reg == CMD_DEQ)
            begin
                entry_prio_next[i] = up_p;
                entry_tag_next[i]  = up_t;
            end
            else if (le[i])
            begin
                entry_prio_next[i] = entry_prio_reg[i];
                entry_tag_next[i]  = entry_tag_reg[i];
            end
            else if (ins)
            begin
                entry_prio_next[i] = prio_reg;
                entry_tag_next[i]  = tag_reg;
            end
            else
            begin
                entry_prio_next[i] = dn_p;
                entry_tag_next[i]  = dn_t;
            end
        end

        always_ff @(posedge clk)
        begin
            if (dp_cmd.exec)
            begin
                entry_prio_reg[i] <= entry_prio_next[i];
                entry_tag_reg[i]  <= entry_tag_next[i];
            end
        end
    end

    // Fill count and result of the operation
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign not_full = count_reg < CNT_W'(CAPACITY);
    assign lim      = (CMP_W'(max_size_reg) > CMP_W'(CAPACITY)) ?
                      CMP_W'(CAPACITY) : CMP_W'(max_size_reg);

    always_comb
    begin
        count_next = count_reg;
        hit_next   = 1'b0;
        rtag_next  = '0;
        rprio_next = '0;
        drop_next  = 1'b0;
        if (cmd_reg == CMD_DEQ)
        begin
            if (count_reg != '0)
            begin
                hit_next   = 1'b1;
                rtag_next  = entry_tag_reg[0];
                rprio_next = entry_prio_reg[0];
                count_next = cnt_m1;
            end
        end
        else if (not_full)
        begin
            // insert, then drop the tail when over the limit
            if (CMP_W'(cnt_inc) > lim)
                drop_next = 1'b1;
            else
                count_next = cnt_inc;
        end
        else
        begin
            drop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (dp_cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            hit_reg   <= hit_next;
            rtag_reg  <= rtag_next;
            rprio_reg <= rprio_next;
            drop_reg  <= drop_next;
        end
    end

    // Load the output register from the updated list
    assign last_idx = cnt_m1[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            out_valid_reg <= hit_reg;
            out_tag_reg   <= rtag_reg;
            out_prio_reg  <= rprio_reg;
            dropped_reg   <= drop_reg;
            count_out_reg <= count_reg;
            if (count_reg == '0)
            begin
                best_reg  <= '1;
                worst_reg <= '1;
            end
            else
            begin
                best_reg  <= entry_prio_reg[0];
                worst_reg <= entry_prio_reg[last_idx];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_tag        = out_tag_reg;
    assign out_priority   = out_prio_reg;
    assign dropped        = dropped_reg;
    assign count          = count_out_reg;
    assign best_priority  = best_reg;
    assign worst_priority = worst_reg;

endmodule

[hdl/bounded_priority_queue.sv]
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Sorted k-best list of (priority, tag) pairs with enqueue and dequeue.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: cmd selects enqueue (insert the pair after
//   entries of equal priority, dropping the tail beyond max_size) or dequeue
//   (remove and return the smallest entry). rsp returns exactly one result per
//   request: the dequeued entry, the drop flag, the fill count and the best
//   and worst priority held (all ones when the list is empty).
//   cfg_we/cfg_wdata write max_size; write it only while the block is idle.
// Timing:
//   A request passes capture, list update and output load, each registered.
//   The load waits while an untaken result holds the output register, and a
//   new request is taken only once the previous one has been loaded. The
//   controller sequence runs a single update of the cell row, whose
//   comparators all work in parallel.
// Reset:
//   Clears the list to empty and sets max_size to 16; entry storage keeps
//   no defined value until written.
// Stall:
//   A new request is taken while a result waits in the output register; the
//   following load is held until that result is taken.
// ----------------------------------------------------------------------------
module bounded_priority_queue
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    bpq_req_if.sink          req,
    bpq_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    dp_cmd_t dp_cmd;

    // Sequence each request
    bpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_cmd    (dp_cmd)
    );

    // Hold and update the sorted list
    bpq_dp #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS),
        .CNT_W    (CNT_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_cmd        (req.cmd),
        .req_priority   (req.priority_req),
        .req_tag        (req.tag),
        .out_valid      (rsp.out_valid),
        .out_tag        (rsp.out_tag),
        .out_priority   (rsp.out_priority),
        .dropped        (rsp.dropped),
        .count          (rsp.count),
        .best_priority  (rsp.best_priority),
        .worst_priority (rsp.worst_priority)
    );

`ifndef NO_ASSERTIONS
    // Fill count never exceeds storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.count <= CNT_W'(CAPACITY)))
        else $error("fill count above capacity");

    // Empty list reports all-ones best and worst
    a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.count == '0) |->
        (rsp.best_priority == '1 && rsp.worst_priority == '1))
        else $error("empty list reports a priority");

    // Sorted order: best never above worst
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.count != '0) |->
        (rsp.best_priority <= rsp.worst_priority))
        else $error("best priority above worst");

    // A drop only comes from an enqueue, which returns no entry
    a_drop_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped) |-> !rsp.out_valid)
        else $error("drop reported with a returned entry");
`endif

endmodule
